>>> src/dual_queue_red_wrr_scheduler_assert.svh
// Assertion macros for the dual-queue RED / WRR scheduler.
// Depends on nothing; included by the top level only.
`ifndef DUAL_QUEUE_RED_WRR_SCHEDULER_ASSERT_SVH
`define DUAL_QUEUE_RED_WRR_SCHEDULER_ASSERT_SVH

`ifndef SYNTHESIS

// Antecedent implies consequent in the same cycle.
`define DQR_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scheduler assertion failed");

// Antecedent implies consequent in the next cycle.
`define DQR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scheduler assertion failed");

`else

`define DQR_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define DQR_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> src/dqr_pkg.sv
// Shared types and constants of the dual-queue RED / WRR scheduler.
// Depends on nothing; used by every module of the block.
package dqr_pkg;

  localparam int QUEUE_LIMIT = 1024;

  localparam int OCC_W      = 11;
  localparam int PROB_W     = 16;
  localparam int RUN_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int LIMIT_W    = 17;
  localparam int PROD_W     = OCC_W + PROB_W;

  localparam logic [LIMIT_W-1:0] QUEUE_LIMIT_V = LIMIT_W'(QUEUE_LIMIT);
  localparam logic [OCC_W-1:0]   OCC_MAX       = '1;
  localparam logic [RUN_W-1:0]   RUN_MAX       = '1;

  // Verdict codes
  localparam logic [2:0] VERDICT_QUEUED        = 3'd0;
  localparam logic [2:0] VERDICT_QUEUED_MARKED = 3'd1;
  localparam logic [2:0] VERDICT_EARLY_DROP    = 3'd2;
  localparam logic [2:0] VERDICT_FORCED_DROP   = 3'd3;
  localparam logic [2:0] VERDICT_SERVED        = 3'd4;
  localparam logic [2:0] VERDICT_EMPTY         = 3'd5;

  // Traffic classes
  localparam logic CLASS_L4S     = 1'b0;
  localparam logic CLASS_CLASSIC = 1'b1;

  // Actions
  localparam logic ACTION_ENQUEUE = 1'b0;
  localparam logic ACTION_DEQUEUE = 1'b1;

  // ECN codes
  localparam logic [1:0] ECN_NOT_ECT = 2'd0;
  localparam logic [1:0] ECN_ECT_L4S = 2'd1;
  localparam logic [1:0] ECN_ECT0    = 2'd2;
  localparam logic [1:0] ECN_CE      = 2'd3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_L4S_MIN_TH     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_L4S_MAX_TH     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CLASSIC_MIN_TH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CLASSIC_MAX_TH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_L4S_MAX_P      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CLASSIC_MAX_P  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_L4S_WEIGHT     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_CLASSIC_WEIGHT = 3'd7;

  typedef struct packed {
    logic              action;
    logic [1:0]        ecn_code;
    logic [PROB_W-1:0] random_fraction;
  } in_word_t;

  typedef struct packed {
    logic [2:0]       verdict;
    logic             traffic_class;
    logic [OCC_W-1:0] l4s_length;
    logic [OCC_W-1:0] classic_length;
  } out_word_t;

  // RED profile of one class
  typedef struct packed {
    logic [OCC_W-1:0]  min_th;
    logic [OCC_W-1:0]  max_th;
    logic [PROB_W-1:0] max_p;
  } red_cfg_t;

  // Dequeue request toward the round-robin arbiter
  typedef struct packed {
    logic serve;
    logic l4s_busy;
    logic classic_busy;
  } wrr_req_t;

  typedef struct packed {
    logic [RUN_W-1:0] l4s_weight;
    logic [RUN_W-1:0] classic_weight;
  } wrr_cfg_t;

endpackage

>>> src/dqr_red.sv
// RED early-action test for one class occupancy.
// Depends on dqr_pkg.
module dqr_red (
  input  logic [dqr_pkg::OCC_W-1:0]  len_i,
  input  dqr_pkg::red_cfg_t          cfg_i,
  input  logic [dqr_pkg::PROB_W-1:0] rand_i,
  output logic                       hit_o
);

  logic [dqr_pkg::OCC_W-1:0]  over_min;
  logic [dqr_pkg::OCC_W-1:0]  span;
  logic [dqr_pkg::PROD_W-1:0] lhs;
  logic [dqr_pkg::PROD_W-1:0] rhs;

  // Linear region: only meaningful when min < len <= max
  assign over_min = len_i - cfg_i.min_th;
  assign span     = cfg_i.max_th - cfg_i.min_th;
  assign lhs      = dqr_pkg::PROD_W'(over_min) * dqr_pkg::PROD_W'(cfg_i.max_p);
  assign rhs      = dqr_pkg::PROD_W'(rand_i) * dqr_pkg::PROD_W'(span);

  always_comb begin
    if (len_i > cfg_i.max_th) begin
      hit_o = 1'b1;
    end else if (len_i <= cfg_i.min_th) begin
      hit_o = 1'b0;
    end else begin
      hit_o = lhs > rhs;
    end
  end

endmodule

>>> src/dqr_wrr.sv
// Weighted round-robin arbiter between the L4S and Classic classes.
// Depends on dqr_pkg; holds the last served class and the run count.
module dqr_wrr (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dqr_pkg::wrr_req_t req_i,
  input  dqr_pkg::wrr_cfg_t cfg_i,
  output logic              class_o
);

  logic                      last_q, last_d;
  logic [dqr_pkg::RUN_W-1:0] run_q, run_d;
  logic                      target;

  always_comb begin
    if (!req_i.classic_busy) begin
      target = dqr_pkg::CLASS_L4S;
    end else if (!req_i.l4s_busy) begin
      target = dqr_pkg::CLASS_CLASSIC;
    end else if (last_q == dqr_pkg::CLASS_L4S) begin
      target = (run_q >= cfg_i.l4s_weight) ? dqr_pkg::CLASS_CLASSIC : dqr_pkg::CLASS_L4S;
    end else begin
      target = (run_q >= cfg_i.classic_weight) ? dqr_pkg::CLASS_L4S : dqr_pkg::CLASS_CLASSIC;
    end
  end

  always_comb begin
    last_d = last_q;
    run_d  = run_q;
    if (req_i.serve) begin
      last_d = target;
      if (target == last_q) begin
        // Same class again: extend the run, saturate at the top
        if (run_q != dqr_pkg::RUN_MAX) begin
          run_d = run_q + 1'b1;
        end
      end else begin
        run_d = dqr_pkg::RUN_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= dqr_pkg::CLASS_L4S;
      run_q  <= '0;
    end else begin
      last_q <= last_d;
      run_q  <= run_d;
    end
  end

  assign class_o = target;

endmodule

>>> src/dual_queue_red_wrr_scheduler.sv
// Dual-queue RED admission with weighted round-robin service, top level.
// Channels: in (in_valid_i/in_ready_o, in_word_i) carries enqueue or dequeue
// words; out (out_valid_o/out_ready_i, out_word_o) returns one result word
// per input word; cfg (cfg_valid_i/cfg_ready_o, cfg_index_i, cfg_data_i)
// writes the thresholds, peak probabilities and weights.
// Datapath: a word accepted into the input register is decided there by the
// RED test and the arbiter, combinationally, and its result is loaded into the
// result register that drives the out channel.
// Throughput: one word per cycle while out_ready_i stays high; the queue
// occupancies are updated at the same edge that loads the result, so the
// next word in the input register already sees them.
// Stall: when the receiver holds out_ready_i low, the result register
// holds, one more word may wait in the input register, and then in_ready_o
// drops until the result word is taken.
// Reset: occupancies, last served class and run count clear to zero (L4S),
// configuration returns to its defaults, both stages empty. cfg_ready_o is
// always high; write configuration only while the block is idle.
`include "dual_queue_red_wrr_scheduler_assert.svh"

module dual_queue_red_wrr_scheduler (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  dqr_pkg::in_word_t                   in_word_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output dqr_pkg::out_word_t                  out_word_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [dqr_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [dqr_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  // Configuration registers
  logic [dqr_pkg::OCC_W-1:0]  l4s_min_q, l4s_max_q, classic_min_q, classic_max_q;
  logic [dqr_pkg::PROB_W-1:0] l4s_p_q, classic_p_q;
  logic [dqr_pkg::RUN_W-1:0]  l4s_w_q, classic_w_q;

  // Queue occupancy
  logic [dqr_pkg::OCC_W-1:0] l4s_occ_q, l4s_occ_d;
  logic [dqr_pkg::OCC_W-1:0] classic_occ_q, classic_occ_d;

  // Pipeline registers
  logic               item_valid_q;
  dqr_pkg::in_word_t  item_q;
  logic               res_valid_q;
  dqr_pkg::out_word_t res_q, res_d;

  logic res_free;
  logic fire;

  logic                       cls;
  logic [dqr_pkg::OCC_W-1:0]  own_occ;
  logic [dqr_pkg::LIMIT_W-1:0] total_occ;
  logic                       forced;
  logic                       hit;
  dqr_pkg::red_cfg_t          red_cfg;
  dqr_pkg::wrr_req_t          wrr_req;
  dqr_pkg::wrr_cfg_t          wrr_cfg;
  logic                       served_class;
  logic                       any_busy;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      l4s_min_q     <= dqr_pkg::OCC_W'(27);
      l4s_max_q     <= dqr_pkg::OCC_W'(80);
      classic_min_q <= dqr_pkg::OCC_W'(100);
      classic_max_q <= dqr_pkg::OCC_W'(300);
      l4s_p_q       <= dqr_pkg::PROB_W'(1311);
      classic_p_q   <= dqr_pkg::PROB_W'(1311);
      l4s_w_q       <= dqr_pkg::RUN_W'(1);
      classic_w_q   <= dqr_pkg::RUN_W'(1);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        dqr_pkg::REG_L4S_MIN_TH:     l4s_min_q     <= cfg_data_i[dqr_pkg::OCC_W-1:0];
        dqr_pkg::REG_L4S_MAX_TH:     l4s_max_q     <= cfg_data_i[dqr_pkg::OCC_W-1:0];
        dqr_pkg::REG_CLASSIC_MIN_TH: classic_min_q <= cfg_data_i[dqr_pkg::OCC_W-1:0];
        dqr_pkg::REG_CLASSIC_MAX_TH: classic_max_q <= cfg_data_i[dqr_pkg::OCC_W-1:0];
        dqr_pkg::REG_L4S_MAX_P:      l4s_p_q       <= cfg_data_i[dqr_pkg::PROB_W-1:0];
        dqr_pkg::REG_CLASSIC_MAX_P:  classic_p_q   <= cfg_data_i[dqr_pkg::PROB_W-1:0];
        dqr_pkg::REG_L4S_WEIGHT:     l4s_w_q       <= cfg_data_i[dqr_pkg::RUN_W-1:0];
        dqr_pkg::REG_CLASSIC_WEIGHT: classic_w_q   <= cfg_data_i[dqr_pkg::RUN_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: the result register frees when empty or taken this cycle
  assign res_free   = !res_valid_q || out_ready_i;
  assign fire       = item_valid_q && res_free;
  assign in_ready_o = !item_valid_q || res_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      item_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= in_word_i;
    end
  end

  // Enqueue classification: ECT(1) and CE go to L4S
  assign cls = (item_q.ecn_code == dqr_pkg::ECN_ECT_L4S ||
                item_q.ecn_code == dqr_pkg::ECN_CE)
             ? dqr_pkg::CLASS_L4S : dqr_pkg::CLASS_CLASSIC;
  assign own_occ   = (cls == dqr_pkg::CLASS_L4S) ? l4s_occ_q : classic_occ_q;
  assign total_occ = dqr_pkg::LIMIT_W'(l4s_occ_q) + dqr_pkg::LIMIT_W'(classic_occ_q);
  assign forced    = (total_occ >= dqr_pkg::QUEUE_LIMIT_V) || (own_occ == dqr_pkg::OCC_MAX);

  always_comb begin
    if (cls == dqr_pkg::CLASS_L4S) begin
      red_cfg.min_th = l4s_min_q;
      red_cfg.max_th = l4s_max_q;
      red_cfg.max_p  = l4s_p_q;
    end else begin
      red_cfg.min_th = classic_min_q;
      red_cfg.max_th = classic_max_q;
      red_cfg.max_p  = classic_p_q;
    end
  end

  dqr_red u_red (
    .len_i  (own_occ),
    .cfg_i  (red_cfg),
    .rand_i (item_q.random_fraction),
    .hit_o  (hit)
  );

  assign any_busy             = (l4s_occ_q != '0) || (classic_occ_q != '0);
  assign wrr_req.l4s_busy     = l4s_occ_q != '0;
  assign wrr_req.classic_busy = classic_occ_q != '0;
  assign wrr_req.serve        = fire && (item_q.action == dqr_pkg::ACTION_DEQUEUE) && any_busy;
  assign wrr_cfg.l4s_weight     = l4s_w_q;
  assign wrr_cfg.classic_weight = classic_w_q;

  dqr_wrr u_wrr (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (wrr_req),
    .cfg_i   (wrr_cfg),
    .class_o (served_class)
  );

  // Decide the verdict and the next occupancy of the word in the input register
  always_comb begin
    l4s_occ_d         = l4s_occ_q;
    classic_occ_d     = classic_occ_q;
    res_d.verdict     = dqr_pkg::VERDICT_EMPTY;
    res_d.traffic_class = dqr_pkg::CLASS_L4S;
    if (item_q.action == dqr_pkg::ACTION_ENQUEUE) begin
      res_d.traffic_class = cls;
      if (forced) begin
        res_d.verdict = dqr_pkg::VERDICT_FORCED_DROP;
      end else if (hit && item_q.ecn_code == dqr_pkg::ECN_NOT_ECT) begin
        res_d.verdict = dqr_pkg::VERDICT_EARLY_DROP;
      end else begin
        res_d.verdict = hit ? dqr_pkg::VERDICT_QUEUED_MARKED : dqr_pkg::VERDICT_QUEUED;
        if (cls == dqr_pkg::CLASS_L4S) begin
          l4s_occ_d = l4s_occ_q + 1'b1;
        end else begin
          classic_occ_d = classic_occ_q + 1'b1;
        end
      end
    end else if (any_busy) begin
      res_d.verdict       = dqr_pkg::VERDICT_SERVED;
      res_d.traffic_class = served_class;
      if (served_class == dqr_pkg::CLASS_L4S) begin
        l4s_occ_d = l4s_occ_q - 1'b1;
      end else begin
        classic_occ_d = classic_occ_q - 1'b1;
      end
    end
    res_d.l4s_length     = l4s_occ_d;
    res_d.classic_length = classic_occ_d;
  end

  // Commit state and load the result only when the word moves on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      l4s_occ_q     <= '0;
      classic_occ_q <= '0;
    end else if (fire) begin
      l4s_occ_q     <= l4s_occ_d;
      classic_occ_q <= classic_occ_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (res_free) begin
      res_valid_q <= item_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = res_valid_q;
  assign out_word_o  = res_q;

  // The combined occupancy never passes the buffer limit
  `DQR_ASSERT_IMPLY(a_occ_limit, clk_i, rst_ni, 1'b1, total_occ <= dqr_pkg::QUEUE_LIMIT_V)
  // A dequeue with something queued yields a served result next cycle
  `DQR_ASSERT_NEXT(a_deq_served, clk_i, rst_ni, wrr_req.serve, res_valid_q && res_q.verdict == dqr_pkg::VERDICT_SERVED)
  // A word blocked by a full result stage stays in the input register
  `DQR_ASSERT_NEXT(a_item_hold, clk_i, rst_ni, item_valid_q && !res_free, item_valid_q && $stable(item_q))

endmodule

>>> dv/dual_queue_red_wrr_scheduler_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the dual-queue RED admission / WRR service block.
// Depends on dqr_pkg and dual_queue_red_wrr_scheduler; a small scoreboard class
// predicts every result word and plain tasks drive the in and cfg channels.

module dual_queue_red_wrr_scheduler_tb;
  import dqr_pkg::*;

  // Worst case is far below this: about 1900 words, each with a long send gap
  // and a long receive stall, plus one long hold-off on the result side.
  localparam longint RUN_LIMIT_NS = 64'd9_600_000;

  typedef logic [CFG_DATA_W-1:0] reg_set_t [8];

  // Predicts admission verdicts, service order and queue lengths, and keeps
  // the expected result words in arrival order.
  class red_wrr_scoreboard;
    logic [OCC_W-1:0]  min_th [2];
    logic [OCC_W-1:0]  max_th [2];
    logic [PROB_W-1:0] max_p  [2];
    logic [RUN_W-1:0]  weight [2];
    logic [OCC_W-1:0]  occ    [2];
    logic              last_cls;
    logic [RUN_W-1:0]  run_len;
    out_word_t         expected_q [$];
    int                errors;

    function new();
      min_th[CLASS_L4S]     = 11'd27;
      max_th[CLASS_L4S]     = 11'd80;
      min_th[CLASS_CLASSIC] = 11'd100;
      max_th[CLASS_CLASSIC] = 11'd300;
      max_p[CLASS_L4S]      = 16'd1311;
      max_p[CLASS_CLASSIC]  = 16'd1311;
      weight[CLASS_L4S]     = 16'd1;
      weight[CLASS_CLASSIC] = 16'd1;
      occ[CLASS_L4S]        = '0;
      occ[CLASS_CLASSIC]    = '0;
      last_cls              = CLASS_L4S;
      run_len               = '0;
      errors                = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_L4S_MIN_TH:     min_th[CLASS_L4S]     = data[OCC_W-1:0];
        REG_L4S_MAX_TH:     max_th[CLASS_L4S]     = data[OCC_W-1:0];
        REG_CLASSIC_MIN_TH: min_th[CLASS_CLASSIC] = data[OCC_W-1:0];
        REG_CLASSIC_MAX_TH: max_th[CLASS_CLASSIC] = data[OCC_W-1:0];
        REG_L4S_MAX_P:      max_p[CLASS_L4S]      = data;
        REG_CLASSIC_MAX_P:  max_p[CLASS_CLASSIC]  = data;
        REG_L4S_WEIGHT:     weight[CLASS_L4S]     = data;
        REG_CLASSIC_WEIGHT: weight[CLASS_CLASSIC] = data;
        default: ;
      endcase
    endfunction

    // Above max always hits, at or below min never; in between compare the
    // linear probability against the random fraction, exactly in integers.
    function bit red_hit(logic cls, logic [PROB_W-1:0] frac);
      longint len, lo, hi;
      len = occ[cls];
      lo  = min_th[cls];
      hi  = max_th[cls];
      if (len > hi) return 1'b1;
      if (len <= lo) return 1'b0;
      return (len - lo) * longint'(max_p[cls]) > longint'(frac) * (hi - lo);
    endfunction

    function void note_word(in_word_t w);
      out_word_t e;
      logic      cls;
      logic      pick;
      bit        hit;
      if (w.action == ACTION_ENQUEUE) begin
        cls = (w.ecn_code == ECN_ECT_L4S || w.ecn_code == ECN_CE) ? CLASS_L4S : CLASS_CLASSIC;
        if (int'(occ[CLASS_L4S]) + int'(occ[CLASS_CLASSIC]) >= QUEUE_LIMIT ||
            occ[cls] == OCC_MAX) begin
          e.verdict = VERDICT_FORCED_DROP;
        end else begin
          hit = red_hit(cls, w.random_fraction);
          if (hit && w.ecn_code == ECN_NOT_ECT) begin
            e.verdict = VERDICT_EARLY_DROP;
          end else begin
            e.verdict = hit ? VERDICT_QUEUED_MARKED : VERDICT_QUEUED;
            occ[cls]++;
          end
        end
      end else if (occ[CLASS_L4S] == 0 && occ[CLASS_CLASSIC] == 0) begin
        e.verdict = VERDICT_EMPTY;
        cls       = CLASS_L4S;
      end else begin
        if (occ[CLASS_CLASSIC] == 0) pick = CLASS_L4S;
        else if (occ[CLASS_L4S] == 0) pick = CLASS_CLASSIC;
        else pick = (run_len >= weight[last_cls]) ? ~last_cls : last_cls;
        if (pick == last_cls) begin
          if (run_len != RUN_MAX) run_len++;
        end else begin
          last_cls = pick;
          run_len  = 1;
        end
        cls = last_cls;
        occ[cls]--;
        e.verdict = VERDICT_SERVED;
      end
      e.traffic_class  = cls;
      e.l4s_length     = occ[CLASS_L4S];
      e.classic_length = occ[CLASS_CLASSIC];
      expected_q.push_back(e);
    endfunction

    function void check_word(out_word_t got);
      out_word_t e;
      if (expected_q.size() == 0) begin
        $error("result word with nothing expected: %p", got);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (got.verdict !== e.verdict) begin
        $error("verdict: expected %0d, got %0d", e.verdict, got.verdict);
        errors++;
      end
      if (got.traffic_class !== e.traffic_class) begin
        $error("traffic_class: expected %0d, got %0d", e.traffic_class, got.traffic_class);
        errors++;
      end
      if (got.l4s_length !== e.l4s_length) begin
        $error("l4s_length: expected %0d, got %0d", e.l4s_length, got.l4s_length);
        errors++;
      end
      if (got.classic_length !== e.classic_length) begin
        $error("classic_length: expected %0d, got %0d", e.classic_length, got.classic_length);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_ready_o;
  in_word_t              in_word_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  out_word_t             out_word_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  // Set while both sides should run back to back with no idling at all.
  bit quiet;

  red_wrr_scoreboard sb = new();

  dual_queue_red_wrr_scheduler dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Gap length for either side: mostly none or short, now and then long.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 19);
    if (r < 10) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic in_word_t make_word(logic act, logic [1:0] ecn, logic [PROB_W-1:0] frac);
    in_word_t w;
    w.action          = act;
    w.ecn_code        = ecn;
    w.random_fraction = frac;
    return w;
  endfunction

  // Offer one word, optionally after a gap, and hold it until the block takes
  // it. Valid is only dropped when a gap really follows, so back-to-back words
  // never see valid lowered and raised in the same step.
  task automatic send_word(in_word_t w);
    int gap;
    gap = quiet ? 0 : idle_len();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Random traffic: enq_pct percent enqueues; the fraction hits both ends of
  // its range now and then so the RED compare sees its extremes.
  task automatic send_random(int count, int enq_pct);
    int               r;
    logic             act;
    logic [PROB_W-1:0] frac;
    for (int n = 0; n < count; n++) begin
      act = ($urandom_range(0, 99) < enq_pct) ? ACTION_ENQUEUE : ACTION_DEQUEUE;
      r   = $urandom_range(0, 15);
      if (r == 0) frac = '0;
      else if (r == 1) frac = '1;
      else frac = PROB_W'($urandom());
      send_word(make_word(act, 2'($urandom_range(0, 3)), frac));
    end
  endtask

  // Stop offering, then wait until every expected result word has come back;
  // the block holds nothing else once that is true.
  task automatic settle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  // Write all eight registers, in index order, once the block is idle.
  task automatic program_regs(reg_set_t vals);
    settle();
    for (int i = 0; i < 8; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= CFG_IDX_W'(i);
      cfg_data_i  <= vals[i];
      do @(posedge clk_i); while (!cfg_ready_o);
    end
    cfg_valid_i <= 1'b0;
  endtask

  // Random register set with the extremes well represented. Thresholds may
  // carry all-ones data, which the 11-bit registers truncate to their top.
  function automatic reg_set_t random_profile();
    reg_set_t vals;
    int       r;
    for (int i = 0; i < 8; i++) begin
      r = $urandom_range(0, 7);
      if (i < REG_L4S_MAX_P) begin
        case (r)
          0:       vals[i] = 16'd0;
          1:       vals[i] = 16'd1024;
          2:       vals[i] = 16'hFFFF;
          default: vals[i] = 16'($urandom_range(0, 400));
        endcase
      end else if (i < REG_L4S_WEIGHT) begin
        case (r)
          0:       vals[i] = 16'd0;
          1:       vals[i] = 16'hFFFF;
          default: vals[i] = 16'($urandom());
        endcase
      end else begin
        case (r)
          0:       vals[i] = 16'd0;
          1:       vals[i] = 16'd1;
          2:       vals[i] = 16'hFFFF;
          default: vals[i] = 16'($urandom_range(1, 8));
        endcase
      end
    end
    return vals;
  endfunction

  // Every handshake is seen here, on the values from before the edge. Note
  // inputs before checking results so the expectation queue stays in order.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_word(in_word_i);
      if (out_valid_o && out_ready_i) sb.check_word(out_word_o);
      if (cfg_valid_i && cfg_ready_o) sb.write_reg(cfg_index_i, cfg_data_i);
    end
  end

  // Result side: random stalls, plus one long hold-off once traffic is going
  // so the input register fills and in_ready_o has to drop.
  initial begin : result_sink
    int stall_left;
    int taken;
    bit held;
    out_ready_i = 1'b0;
    stall_left  = 0;
    taken       = 0;
    held        = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) taken++;
      if (!held && taken >= 120) begin
        held       = 1'b1;
        stall_left = 90;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if (!quiet) stall_left = idle_len();
      end
    end
  end

  initial begin : stimulus
    reg_set_t vals;
    in_valid_i  = 1'b0;
    in_word_i   = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    rst_ni      = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset defaults, registers untouched: dequeue from empty queues, one
    // enqueue per ECN code, then two services under unit weights.
    send_word(make_word(ACTION_DEQUEUE, ECN_NOT_ECT, 16'h0000));
    send_word(make_word(ACTION_ENQUEUE, ECN_NOT_ECT, 16'h0000));
    send_word(make_word(ACTION_ENQUEUE, ECN_ECT_L4S, 16'hFFFF));
    send_word(make_word(ACTION_ENQUEUE, ECN_ECT0,    16'h0000));
    send_word(make_word(ACTION_ENQUEUE, ECN_CE,      16'hFFFF));
    send_word(make_word(ACTION_DEQUEUE, ECN_CE,      16'hFFFF));
    send_word(make_word(ACTION_DEQUEUE, ECN_ECT0,    16'h0000));

    // Tight L4S profile so the linear region is reached in a few words,
    // Classic with min above max, L4S weight zero and Classic weight two.
    // Order: l4s min/max, classic min/max, l4s/classic max_p, l4s/classic weight.
    program_regs('{16'd1, 16'd4, 16'd5, 16'd2, 16'hFFFF, 16'd0, 16'd0, 16'd2});
    send_word(make_word(ACTION_ENQUEUE, ECN_ECT_L4S, 16'hFFFF));
    send_word(make_word(ACTION_ENQUEUE, ECN_CE,      16'hFFFF));
    send_word(make_word(ACTION_ENQUEUE, ECN_ECT_L4S, 16'h0000));
    send_word(make_word(ACTION_ENQUEUE, ECN_CE,      16'h0000));
    send_word(make_word(ACTION_ENQUEUE, ECN_ECT_L4S, 16'hFFFF));
    send_word(make_word(ACTION_ENQUEUE, ECN_ECT0,    16'hFFFF));
    send_word(make_word(ACTION_ENQUEUE, ECN_ECT0,    16'h0000));
    // Classic is now above its max: Not-ECT drops early, ECT0 gets marked.
    send_word(make_word(ACTION_ENQUEUE, ECN_NOT_ECT, 16'hFFFF));
    send_word(make_word(ACTION_ENQUEUE, ECN_ECT0,    16'hFFFF));
    for (int n = 0; n < 7; n++)
      send_word(make_word(ACTION_DEQUEUE, ECN_NOT_ECT, 16'h0000));

    // Mixed random traffic; the long result hold-off lands in here.
    program_regs(random_profile());
    send_random(200, 55);

    // Fill: no early action on either class, both sides back to back, until
    // the shared buffer is full and arrivals take forced drops.
    program_regs('{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000,
                   16'hFFFF, 16'd1});
    quiet = 1'b1;
    send_random(1080, 98);
    settle();
    quiet = 1'b0;

    // Drain from a deep buffer with the linear region placed at the depths
    // the queues actually have, so the probability compare sees large lengths.
    vals = random_profile();
    vals[REG_L4S_MIN_TH]     = 16'($urandom_range(150, 500));
    vals[REG_L4S_MAX_TH]     = vals[REG_L4S_MIN_TH] + 16'($urandom_range(50, 500));
    vals[REG_CLASSIC_MIN_TH] = 16'($urandom_range(150, 500));
    vals[REG_CLASSIC_MAX_TH] = vals[REG_CLASSIC_MIN_TH] + 16'($urandom_range(50, 500));
    program_regs(vals);
    send_random(400, 20);

    // Two more random settings with balanced traffic.
    program_regs(random_profile());
    send_random(100, 50);
    program_regs(random_profile());
    send_random(100, 50);

    in_valid_i <= 1'b0;
    settle();
    repeat (4) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("dual_queue_red_wrr_scheduler_tb passed");
    end else begin
      $display("dual_queue_red_wrr_scheduler_tb failed");
    end
    $finish;
  end

  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("dual_queue_red_wrr_scheduler_tb failed");
    $finish;
  end

endmodule
